// ===== rtl/slcg_pkg.sv =====
// shared constants, types and helpers for the single-linkage cluster gap block
package slcg_pkg;

  localparam int MaxPoints = 256;
  localparam int CoordBits = 12;
  localparam int FracBits  = 20;
  localparam int IdxBits   = $clog2(MaxPoints);
  localparam int CntBits   = IdxBits + 1;
  localparam int SqBits    = 2 * CoordBits + 1;
  localparam int RootBits  = CoordBits + 1 + FracBits;
  localparam int KBits     = 9;
  localparam int StatBits  = 2;
  localparam int DiffBits  = CoordBits + 1;
  localparam int ProdBits  = 2 * CoordBits;
  // root iterations: one result bit per cycle
  localparam int RootSteps = RootBits;
  localparam int RemBits   = RootBits + 2;
  localparam int RadBits   = 2 * RootBits;
  localparam int RstBits   = $clog2(RootSteps + 1);

  localparam logic [KBits-1:0]   KReset  = KBits'(2);
  localparam logic [SqBits-1:0]  SqInf   = '1;

  localparam logic [StatBits-1:0] StatOk     = 2'd0;
  localparam logic [StatBits-1:0] StatNoAns  = 2'd1;
  localparam logic [StatBits-1:0] StatFewPts = 2'd2;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic [SqBits-1:0]           sq_t;
  typedef logic [IdxBits-1:0]          idx_t;
  typedef logic [CntBits-1:0]          cnt_t;

  // request and reply between the tree search and the root unit
  typedef struct packed {
    logic start;
    sq_t  value;
  } root_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [RootBits-1:0] root;
  } root_rsp_t;

endpackage

// ===== rtl/slcg_if.sv =====
// valid/ready channel interfaces for points, results and configuration
interface slcg_point_if;
  import slcg_pkg::*;
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  logic   last_point;
  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface slcg_result_if;
  import slcg_pkg::*;
  logic                valid;
  logic                ready;
  sq_t                 squared_gap;
  logic [RootBits-1:0] gap_root;
  logic [StatBits-1:0] status;
  modport source (output valid, squared_gap, gap_root, status, input ready);
  modport sink   (input valid, squared_gap, gap_root, status, output ready);
endinterface

interface slcg_cfg_if;
  import slcg_pkg::*;
  logic             valid;
  logic             ready;
  logic [KBits-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/slcg_root.sv =====
// iterative fixed-point square root, one result bit per cycle
module slcg_root import slcg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  root_req_t req_i,
  output root_rsp_t rsp_o
);

  logic [RadBits-1:0]  rad_q, rad_d;
  logic [RemBits-1:0]  rem_q, rem_d;
  logic [RootBits-1:0] root_q, root_d;
  logic [RstBits-1:0]  cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [RemBits-1:0]  rem_sh, trial;

  always_comb begin
    rem_sh = {rem_q[RemBits-3:0], rad_q[RadBits-1 -: 2]};
    trial  = {root_q, 2'b01};
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rad_d  = {{(RadBits-SqBits-2*FracBits){1'b0}}, req_i.value, {(2*FracBits){1'b0}}};
      rem_d  = '0;
      root_d = '0;
      cnt_d  = RstBits'(RootSteps);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[RadBits-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[RootBits-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[RootBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - RstBits'(1);
      if (cnt_q == RstBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

// ===== rtl/single_linkage_cluster_gap_core.sv =====
// top level: point store, prim tree search, edge selection and result register
//
// Points load at one item per cycle into a 256-entry coordinate memory. The
// item marked last_point starts the computation and the input stalls until
// its result has been taken. Prim's algorithm runs over the complete graph.
// A second memory holds, per point, an in-tree flag and the running best
// distance, and once a point joins the tree it holds that point's tree edge.
// That memory is first cleared, with point 0 marked in the tree. Each of the
// n-1 passes sweeps all n points (one read per cycle plus a pipeline bubble)
// with a pick step after it, carrying a read-modify-write forward. Each tree
// edge is then ranked against all tree edges by another sweep to find the
// (n-k+1)-th smallest, which then passes through the bit-serial square root.
// k at or above n gives the smallest tree edge; k of zero or one and sets of
// fewer than two points return a status in the cycle after the last item.
module single_linkage_cluster_gap_core import slcg_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  slcg_point_if.sink    pt_i,
  slcg_cfg_if.sink      cfg_i,
  slcg_result_if.source res_o
);

  typedef enum logic [7:0] {
    StLoad  = 8'b0000_0001,
    StPrim  = 8'b0000_0010,
    StPick  = 8'b0000_0100,
    StRank  = 8'b0000_1000,
    StRoot  = 8'b0001_0000,
    StWaitR = 8'b0010_0000,
    StOut   = 8'b0100_0000,
    StPre   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [KBits-1:0] k_q;
  cnt_t             n_q, n_d;

  // point memory
  logic [2*CoordBits-1:0] pt_mem [MaxPoints];
  logic [2*CoordBits-1:0] pt_rd_q;
  logic                   pt_we;
  idx_t                   pt_wa, pt_ra;

  // in-tree flag with best distance, later the tree edge of each point
  logic [SqBits:0] bd_mem [MaxPoints];
  logic [SqBits:0] bd_rd_q;
  logic            bd_we;
  idx_t            bd_wa, bd_ra;
  logic [SqBits:0] bd_wd;

  // sweep control
  cnt_t   i_q, i_d;        // issue index
  logic   v1_q;            // read in flight
  idx_t   a1_q;            // index of read in flight
  cnt_t   step_q, step_d;  // tree edges found
  coord_t cx_q, cy_q;      // current tree point
  logic   fnd_q, fnd_d;
  idx_t   pick_q, pick_d;
  sq_t    pd_q, pd_d;
  // rank control
  cnt_t   e_q, e_d;        // candidate edge index
  sq_t    ev_q, ev_d;
  cnt_t   lt_q, lt_d, le_q, le_d;
  cnt_t   target_q;
  sq_t    ans_q, ans_d;
  logic   epre_q, epre_d;  // candidate edge read pending

  // result register
  logic                rv_q, rv_d;
  sq_t                 rsq_q, rsq_d;
  logic [RootBits-1:0] rrt_q, rrt_d;
  logic [StatBits-1:0] rst_q, rst_d;

  root_req_t rreq;
  root_rsp_t rrsp;

  slcg_root u_root (.clk_i, .rst_ni, .req_i(rreq), .rsp_o(rrsp));

  assign cfg_i.ready = 1'b1;
  assign pt_i.ready  = (state_q == StLoad);

  logic   pt_acc;
  assign pt_acc = pt_i.valid && pt_i.ready;

  // distance from current point to fetched point
  logic signed [DiffBits-1:0] dx, dy;
  logic [DiffBits-1:0]        ax, ay;
  logic [ProdBits-1:0]        px, py;
  sq_t                        pair_dist;
  sq_t                        best_new;
  coord_t                     fx, fy;

  always_comb begin
    fx   = coord_t'(pt_rd_q[2*CoordBits-1:CoordBits]);
    fy   = coord_t'(pt_rd_q[CoordBits-1:0]);
    dx   = DiffBits'(fx) - DiffBits'(cx_q);
    dy   = DiffBits'(fy) - DiffBits'(cy_q);
    ax   = dx[DiffBits-1] ? DiffBits'(-dx) : DiffBits'(dx);
    ay   = dy[DiffBits-1] ? DiffBits'(-dy) : DiffBits'(dy);
    // magnitudes stay below 2^CoordBits, so the top bit is always clear
    px   = ProdBits'(ax[DiffBits-2:0]) * ProdBits'(ax[DiffBits-2:0]);
    py   = ProdBits'(ay[DiffBits-2:0]) * ProdBits'(ay[DiffBits-2:0]);
    pair_dist = SqBits'(px) + SqBits'(py);
    best_new  = (pair_dist < bd_rd_q[SqBits-1:0]) ? pair_dist : bd_rd_q[SqBits-1:0];
  end

  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    i_d      = i_q;
    step_d   = step_q;
    fnd_d    = fnd_q;
    pick_d   = pick_q;
    pd_d     = pd_q;
    e_d      = e_q;
    ev_d     = ev_q;
    lt_d     = lt_q;
    le_d     = le_q;
    ans_d    = ans_q;
    epre_d   = 1'b0;
    rv_d     = rv_q;
    rsq_d    = rsq_q;
    rrt_d    = rrt_q;
    rst_d    = rst_q;
    pt_we    = 1'b0;
    pt_wa    = n_q[IdxBits-1:0];
    pt_ra    = i_q[IdxBits-1:0];
    bd_we    = 1'b0;
    bd_wa    = a1_q;
    bd_wd    = {1'b0, best_new};
    bd_ra    = i_q[IdxBits-1:0];
    rreq.start = 1'b0;
    rreq.value = ans_q;

    case (state_q)
      StLoad: begin
        if (pt_acc) begin
          if (n_q != cnt_t'(MaxPoints)) begin
            pt_we = 1'b1;
            n_d   = n_q + cnt_t'(1);
          end
          if (pt_i.last_point) begin
            if (n_d < cnt_t'(2)) begin
              rv_d = 1'b1; rsq_d = '0; rrt_d = '0; rst_d = StatFewPts;
              n_d = '0;
              state_d = StOut;
            end else if (k_q <= KBits'(1)) begin
              rv_d = 1'b1; rsq_d = '0; rrt_d = '0; rst_d = StatNoAns;
              n_d = '0;
              state_d = StOut;
            end else begin
              i_d = '0;
              state_d = StPre;
            end
          end
        end
      end
      // clear best distances; mark point 0 in tree
      StPre: begin
        bd_we = 1'b1;
        bd_wa = i_q[IdxBits-1:0];
        bd_wd = {(i_q == '0), SqInf};
        if (i_q == n_q - cnt_t'(1)) begin
          i_d    = '0;
          step_d = '0;
          fnd_d  = 1'b0;
          state_d = StPick;
        end else begin
          i_d = i_q + cnt_t'(1);
        end
      end
      // sweep: compare distance to current point, update best, track min
      StPrim: begin
        if (v1_q && !bd_rd_q[SqBits]) begin
          bd_we = 1'b1;
          if (!fnd_q || best_new < pd_q) begin
            fnd_d  = 1'b1;
            pick_d = a1_q;
            pd_d   = best_new;
          end
        end
        if (i_q != n_q) begin
          i_d = i_q + cnt_t'(1);
        end else if (!v1_q || a1_q == IdxBits'(n_q - cnt_t'(1))) begin
          state_d = StPick;
        end
      end
      // record pick as its tree edge, fetch new current point
      StPick: begin
        if (step_q != '0) begin
          bd_we   = 1'b1;
          bd_wa   = pick_q;
          bd_wd   = {1'b1, pd_q};
        end
        pt_ra = (step_q == '0) ? '0 : pick_q;
        if (step_q == n_q - cnt_t'(1)) begin
          e_d    = cnt_t'(1);
          i_d    = '0;
          lt_d   = '0;
          le_d   = '0;
          epre_d = 1'b1;
          state_d = StRank;
        end else begin
          step_d = step_q + cnt_t'(1);
          i_d    = '0;
          fnd_d  = 1'b0;
          state_d = StPrim;
        end
      end
      // rank each tree edge (points 1..n-1) against all of them
      StRank: begin
        bd_ra = epre_q ? e_q[IdxBits-1:0] : i_q[IdxBits-1:0];
        if (epre_q) begin
          i_d = '0;
        end else if (i_q == '0) begin
          // candidate edge arrives, count sweep starts at point 1
          ev_d = bd_rd_q[SqBits-1:0];
          i_d  = cnt_t'(1);
        end else begin
          if (v1_q) begin
            if (bd_rd_q[SqBits-1:0] < ev_q)  lt_d = lt_q + cnt_t'(1);
            if (bd_rd_q[SqBits-1:0] <= ev_q) le_d = le_q + cnt_t'(1);
          end
          if (i_q != step_q + cnt_t'(1)) begin
            i_d = i_q + cnt_t'(1);
          end else if (lt_d <= target_q && target_q < le_d) begin
            ans_d   = ev_q;
            state_d = StRoot;
          end else begin
            e_d    = e_q + cnt_t'(1);
            lt_d   = '0;
            le_d   = '0;
            epre_d = 1'b1;
          end
        end
      end
      StRoot: begin
        rreq.start = 1'b1;
        state_d    = StWaitR;
      end
      StWaitR: begin
        if (rrsp.done) begin
          rv_d  = 1'b1;
          rsq_d = ans_q;
          rrt_d = rrsp.root;
          rst_d = StatOk;
          n_d   = '0;
          state_d = StOut;
        end
      end
      StOut: begin
        if (res_o.ready) begin
          rv_d    = 1'b0;
          state_d = StLoad;
        end
      end
      default: state_d = StLoad;
    endcase
  end

  // issued read valid: prim sweep reads 0..n-1, rank sweep reads 1..n-1
  logic issue;
  always_comb begin
    issue = 1'b0;
    if (state_q == StPrim)  issue = (i_q != n_q);
    if (state_q == StRank)  issue = !epre_q && (i_q != '0) && (i_q <= step_q);
  end

  always_ff @(posedge clk_i) begin
    if (pt_we) pt_mem[pt_wa] <= {pt_i.point_x, pt_i.point_y};
    pt_rd_q <= pt_mem[pt_ra];
    if (bd_we) bd_mem[bd_wa] <= bd_wd;
    bd_rd_q <= bd_mem[bd_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      k_q     <= KReset;
      n_q     <= '0;
      i_q     <= '0;
      v1_q    <= 1'b0;
      step_q  <= '0;
      fnd_q   <= 1'b0;
      e_q     <= '0;
      lt_q    <= '0;
      le_q    <= '0;
      epre_q  <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) k_q <= cfg_i.data;
      n_q     <= n_d;
      i_q     <= i_d;
      v1_q    <= issue;
      step_q  <= step_d;
      fnd_q   <= fnd_d;
      e_q     <= e_d;
      lt_q    <= lt_d;
      le_q    <= le_d;
      epre_q  <= epre_d;
      rv_q    <= rv_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    a1_q   <= i_q[IdxBits-1:0];
    pick_q <= pick_d;
    pd_q   <= pd_d;
    ev_q   <= ev_d;
    ans_q  <= ans_d;
    rsq_q  <= rsq_d;
    rrt_q  <= rrt_d;
    rst_q  <= rst_d;
    // point fetched in the pick cycle arrives in the first sweep cycle
    if (state_q == StPrim && i_q == '0) begin
      cx_q <= coord_t'(pt_rd_q[2*CoordBits-1:CoordBits]);
      cy_q <= coord_t'(pt_rd_q[CoordBits-1:0]);
    end
    if (state_q == StPre) begin
      // rank target n-k, or 0 when k is at or above n
      target_q <= (cnt_t'(k_q) < n_q) ? n_q - cnt_t'(k_q) : '0;
    end
  end

  assign res_o.valid       = rv_q;
  assign res_o.squared_gap = rsq_q;
  assign res_o.gap_root    = rrt_q;
  assign res_o.status      = rst_q;

endmodule

// ===== test/slcg_test_if.sv =====
// testbench copy note: interfaces come from the rtl; this file holds testbench-side helpers
`timescale 1ns / 1ps
package slcg_test_pkg;
  import slcg_pkg::*;

  typedef struct {
    coord_t px;
    coord_t py;
    logic   last;
  } point_item_t;

  typedef struct {
    sq_t                 sq;
    logic [RootBits-1:0] root;
    logic [StatBits-1:0] status;
  } gap_result_t;
endpackage

// ===== test/single_linkage_cluster_gap_core_test.sv =====
// testbench for the single-linkage cluster gap core: random point sets checked against a prim predictor
`timescale 1ns / 1ps
module single_linkage_cluster_gap_core_test;
  import slcg_pkg::*;
  import slcg_test_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  slcg_point_if  pt_if ();
  slcg_cfg_if    cfg_if ();
  slcg_result_if res_if ();

  single_linkage_cluster_gap_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pt_i   (pt_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  // 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state: a copy of the point store and the cluster count
  coord_t      set_x[$];
  coord_t      set_y[$];
  logic [8:0]  k_model = KReset;

  point_item_t pending_points[$];
  gap_result_t expected_gaps[$];

  int  n_errors = 0;
  int  cycle_count = 0;
  int  offered_count = 0;    // items put on the point channel
  int  accepted_count = 0;   // items taken by the block
  bit  hold_req = 1'b0;      // long receiver stall requested
  int  hold_count = 0;       // cycles of the long stall so far
  int  burst_left = 0;
  int  gap_left = 0;
  int  stall_mode = 0;

  // bit-pair square root, floor(sqrt(s) * 2^20)
  function automatic logic [RootBits-1:0] gap_sqrt(longint unsigned s);
    longint unsigned root, rem, trial, pair;
    root = 0;
    rem = 0;
    for (int i = 0; i < 32 + FracBits; i++) begin
      pair = (i < 32) ? ((s >> (62 - 2 * i)) & 3) : 0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root[RootBits-1:0];
  endfunction

  // answer for the stored set: (n-k+1)-th smallest spanning-tree edge via prim
  function automatic gap_result_t cluster_gap(logic [8:0] k);
    gap_result_t r;
    int n, cur, pick, idx;
    longint unsigned best[], edges[$], d, pick_d, dx, dy;
    bit in_tree[];
    bit found;
    n = set_x.size();
    r.sq = '0;
    r.root = '0;
    if (n < 2) begin
      r.status = StatFewPts;
      return r;
    end
    if (k <= 1) begin
      r.status = StatNoAns;
      return r;
    end
    best = new[n];
    in_tree = new[n];
    foreach (best[i]) begin
      best[i] = '1;
      in_tree[i] = 1'b0;
    end
    in_tree[0] = 1'b1;
    cur = 0;
    for (int s = 1; s < n; s++) begin
      found = 1'b0;
      pick = 0;
      pick_d = '1;
      for (int i = 0; i < n; i++) begin
        if (in_tree[i]) continue;
        dx = (set_x[cur] > set_x[i]) ? longint'(set_x[cur]) - longint'(set_x[i])
                                     : longint'(set_x[i]) - longint'(set_x[cur]);
        dy = (set_y[cur] > set_y[i]) ? longint'(set_y[cur]) - longint'(set_y[i])
                                     : longint'(set_y[i]) - longint'(set_y[cur]);
        d = dx * dx + dy * dy;
        if (d < best[i]) best[i] = d;
        if (!found || best[i] < pick_d) begin
          found = 1'b1;
          pick = i;
          pick_d = best[i];
        end
      end
      in_tree[pick] = 1'b1;
      edges.insert(edges.size(), pick_d);
      cur = pick;
    end
    edges.sort();
    idx = (int'(k) < n) ? n - int'(k) : 0;
    r.sq = sq_t'(edges[idx]);
    r.root = gap_sqrt(edges[idx]);
    r.status = StatOk;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $realtime, what);
    n_errors++;
  endtask

  // queue one point; the predictor applies it when the item is accepted
  task automatic queue_point(coord_t px, coord_t py, logic last);
    point_item_t it;
    it.px = px;
    it.py = py;
    it.last = last;
    pending_points.insert(pending_points.size(), it);
  endtask

  task automatic queue_set(int n, int spread);
    coord_t px, py;
    for (int i = 0; i < n; i++) begin
      if (spread == 0) begin
        px = coord_t'($urandom);
        py = coord_t'($urandom);
      end else begin
        px = coord_t'($urandom_range(2 * spread) - spread);
        py = coord_t'($urandom_range(2 * spread) - spread);
      end
      queue_point(px, py, i == n - 1);
    end
  endtask

  // wait until the block drained everything queued so far
  task automatic wait_idle();
    while (pending_points.size() != 0 || expected_gaps.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_k(logic [8:0] k);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= k;
    do @(posedge clk_i); while (!cfg_if.ready);
    k_model = k;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // point driver: bursts with random gaps, fed from pending_points
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pt_if.valid      <= 1'b0;
      pt_if.point_x    <= '0;
      pt_if.point_y    <= '0;
      pt_if.last_point <= 1'b0;
    end else if (pt_if.valid && accepted_count != offered_count) begin
      // hold the offered item until it is taken
    end else if (pending_points.size() != 0 && gap_left == 0) begin
      pt_if.valid      <= 1'b1;
      pt_if.point_x    <= pending_points[0].px;
      pt_if.point_y    <= pending_points[0].py;
      pt_if.last_point <= pending_points[0].last;
      offered_count++;
      if (burst_left == 0) begin
        burst_left = $urandom_range(20, 1);
        gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(4);
      end else begin
        burst_left--;
      end
    end else begin
      pt_if.valid <= 1'b0;
      if (gap_left > 0) gap_left--;
    end
  end

  // acceptance of points: apply to the predictor
  always @(posedge clk_i) begin
    if (rst_ni && pt_if.valid && pt_if.ready) begin
      void'(pending_points.pop_front());
      accepted_count++;
      if (set_x.size() < MaxPoints) begin
        set_x.insert(set_x.size(), pt_if.point_x);
        set_y.insert(set_y.size(), pt_if.point_y);
      end
      if (pt_if.last_point) begin
        expected_gaps.insert(expected_gaps.size(), cluster_gap(k_model));
        set_x.delete();
        set_y.delete();
      end
    end
  end

  // receiver stall pattern, changes its mode now and then
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if ($urandom_range(200) == 0) stall_mode = $urandom_range(2);
      if (hold_req && hold_count < 3000) begin
        res_if.ready <= 1'b0;
        hold_count++;
      end
      else if (stall_mode == 0) res_if.ready <= 1'b1;
      else if (stall_mode == 1) res_if.ready <= ($urandom_range(3) != 0);
      else res_if.ready <= ($urandom_range(3) == 0);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    gap_result_t e;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_gaps.size() == 0) begin
        report_mismatch("result with none expected");
      end else begin
        e = expected_gaps.pop_front();
        if (res_if.status !== e.status)
          report_mismatch($sformatf("status %0d want %0d", res_if.status, e.status));
        if (res_if.squared_gap !== e.sq)
          report_mismatch($sformatf("squared_gap %0d want %0d", res_if.squared_gap, e.sq));
        if (res_if.gap_root !== e.root)
          report_mismatch($sformatf("gap_root %0h want %0h", res_if.gap_root, e.root));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 4000000) begin
      $display("single_linkage_cluster_gap_core_test: FAIL");
      $finish;
    end
  end

  initial begin
    logic [8:0] k_pick;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset k of 2, single point, coordinate extremes, duplicates
    queue_point(12'sd5, -12'sd3, 1'b1);
    queue_point(coord_t'(-2048), coord_t'(-2048), 1'b0);
    queue_point(12'sd2047, 12'sd2047, 1'b1);
    queue_point(12'sd1, 12'sd1, 1'b0);
    queue_point(12'sd1, 12'sd1, 1'b0);
    queue_point(coord_t'(-2048), 12'sd2047, 1'b1);
    queue_point(12'sd0, 12'sd0, 1'b0);
    queue_point(12'sd3, 12'sd4, 1'b0);
    queue_point(-12'sd7, 12'sd9, 1'b0);
    queue_point(12'sd100, -12'sd50, 1'b1);
    wait_idle();
    write_k(9'd1);
    queue_set(5, 0);
    queue_set(1, 0);
    wait_idle();
    write_k(9'd0);
    queue_set(3, 0);
    wait_idle();
    write_k(9'd511);
    queue_set(6, 0);
    wait_idle();
    write_k(9'd256);
    queue_set(4, 100);
    wait_idle();

    // full store, extra points dropped, last mark on a dropped point
    write_k(9'd3);
    queue_set(260, 0);
    wait_idle();

    // long receiver hold-off while points keep coming
    hold_req = 1'b1;
    queue_set(4, 10);
    queue_set(4, 10);
    queue_set(4, 10);
    wait (hold_count == 3000);
    hold_req = 1'b0;
    wait_idle();

    // random phases with varying k, mostly small sets
    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(3))
        0: k_pick = 9'd2;
        1: k_pick = 9'($urandom_range(5, 2));
        2: k_pick = 9'($urandom_range(511));
        default: k_pick = 9'd256;
      endcase
      write_k(k_pick);
      for (int s = 0; s < 14; s++)
        queue_set($urandom_range(12, 1), ($urandom_range(1) == 0) ? 0 : $urandom_range(30));
      wait_idle();
    end

    wait_idle();
    if (n_errors == 0) begin
      $display("single_linkage_cluster_gap_core_test: PASS");
    end else begin
      $display("single_linkage_cluster_gap_core_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/slcg_pkg.sv
rtl/slcg_if.sv
rtl/slcg_root.sv
rtl/single_linkage_cluster_gap_core.sv
test/slcg_test_if.sv
test/single_linkage_cluster_gap_core_test.sv
